// ===== rtl/http_response_key_value_parser_unit_defines.svh =====
// assertion macros for the key/value parser rtl
`ifndef HTTP_RESPONSE_KEY_VALUE_PARSER_UNIT_DEFINES_SVH
`define HTTP_RESPONSE_KEY_VALUE_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define HKVP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hkvp same-cycle check failed");

// next-cycle implication
`define HKVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hkvp next-cycle check failed");

`endif

// ===== rtl/hkvp_pkg.sv =====
// shared constants, codes and control structs of the key/value parser
package hkvp_pkg;

	localparam int TOKEN_CAPACITY = 32;
	localparam int STORE_DEPTH    = TOKEN_CAPACITY - 1;
	localparam int PTR_W          = $clog2(STORE_DEPTH);
	localparam int FILL_W         = $clog2(TOKEN_CAPACITY + 1);

	localparam logic [7:0] CHAR_FIRST = 8'd33;
	localparam logic [7:0] CHAR_STOP  = 8'd127;

	localparam logic [FILL_W-1:0] HTTP_LEN = FILL_W'(5);
	localparam logic [FILL_W-1:0] CODE_LEN = FILL_W'(3);
	localparam logic [FILL_W-1:0] MARK_LEN = FILL_W'(7);

	typedef enum logic [1:0] {
		ACT_DATA = 2'd0,
		ACT_EOS  = 2'd1,
		ACT_ERR  = 2'd2,
		ACT_NEW  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_KEY    = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_200   = 2'd1,
		STAT_HTTP_ERR = 2'd2,
		STAT_READ_ERR = 2'd3
	} status_t;

	typedef struct packed {
		logic    clear;
		logic    feed_key;
		logic    feed_val;
		logic    hold_key;
		logic    emit_key;
		logic    emit_val;
		logic    load_status;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic key_end;
		logic val_end;
		logic hit_http;
		logic hit_200;
		logic hit_mark;
		logic key_done;
		logic val_done;
	} dp_sts_t;

	function automatic logic [7:0] http_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = "H";
			3'd1: c = "T";
			3'd2: c = "T";
			3'd3: c = "P";
			3'd4: c = "/";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] code_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = "2";
			3'd1: c = "0";
			3'd2: c = "0";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] mark_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = ">";
			3'd1: c = "g";
			3'd2: c = "n";
			3'd3: c = "I";
			3'd4: c = "O";
			3'd5: c = "T";
			3'd6: c = "<";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/hkvp_datapath.sv =====
// token stores, fill counters, match flags, emission pointer and output register
module hkvp_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           data_byte,
	input  logic                 m_tready,
	input  hkvp_pkg::dp_cmd_t    cmd,
	output hkvp_pkg::dp_sts_t    sts,
	output logic                 out_valid,
	output hkvp_pkg::kind_t      out_kind,
	output logic [7:0]           out_char,
	output hkvp_pkg::status_t    out_status,
	output logic                 out_last
);

	logic [7:0] key_store [hkvp_pkg::STORE_DEPTH];
	logic [7:0] value_store [hkvp_pkg::STORE_DEPTH];

	logic [hkvp_pkg::FILL_W-1:0] key_fill_q;
	logic [hkvp_pkg::FILL_W-1:0] value_fill_q;
	logic [hkvp_pkg::PTR_W-1:0]  ptr_q;
	logic                        http_q;
	logic                        ok_q;
	logic                        mark_q;
	logic                        out_valid_q;
	hkvp_pkg::kind_t             kind_q;
	logic [7:0]                  char_q;
	hkvp_pkg::status_t           status_q;
	logic                        last_q;

	logic                        printable;
	logic                        key_room;
	logic                        val_room;
	logic                        key_first;
	logic [2:0]                  pos;
	logic [hkvp_pkg::FILL_W-1:0] ptr_next;
	logic                        load;

	localparam logic [hkvp_pkg::FILL_W-1:0] FILL_FULL = hkvp_pkg::FILL_W'(hkvp_pkg::STORE_DEPTH);
	localparam logic [hkvp_pkg::FILL_W-1:0] FILL_OVER =
		hkvp_pkg::FILL_W'(hkvp_pkg::TOKEN_CAPACITY);

	assign printable = (data_byte >= hkvp_pkg::CHAR_FIRST) && (data_byte < hkvp_pkg::CHAR_STOP);
	assign key_room  = key_fill_q < FILL_FULL;
	assign val_room  = value_fill_q < FILL_FULL;
	assign key_first = key_fill_q == '0;
	assign pos       = key_fill_q[2:0];
	assign ptr_next  = hkvp_pkg::FILL_W'(ptr_q) + hkvp_pkg::FILL_W'(1);
	assign load      = cmd.load_status || cmd.emit_key || cmd.emit_val;

	always_comb begin
		sts.out_free = !out_valid_q || m_tready;
		sts.key_end  = !printable && (key_fill_q != '0) && (key_fill_q < FILL_OVER);
		sts.val_end  = !printable && (value_fill_q != '0) && (value_fill_q < FILL_OVER);
		sts.hit_http = sts.key_end && (key_fill_q >= hkvp_pkg::HTTP_LEN) && http_q;
		sts.hit_200  = sts.key_end && (key_fill_q == hkvp_pkg::CODE_LEN) && ok_q;
		sts.hit_mark = sts.key_end && (key_fill_q == hkvp_pkg::MARK_LEN) && mark_q;
		sts.key_done = ptr_next == key_fill_q;
		sts.val_done = ptr_next == value_fill_q;
	end

	// fill counters, pointer and valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_fill_q   <= '0;
			value_fill_q <= '0;
			ptr_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				key_fill_q   <= '0;
				value_fill_q <= '0;
			end else if (cmd.emit_val && sts.val_done) begin
				key_fill_q   <= '0;
				value_fill_q <= '0;
			end else if (cmd.feed_key) begin
				if (printable) begin
					key_fill_q <= key_room ? key_fill_q + hkvp_pkg::FILL_W'(1) : FILL_OVER;
				end else if (!(cmd.hold_key && sts.key_end)) begin
					key_fill_q <= '0;
				end
			end else if (cmd.feed_val) begin
				if (printable) begin
					value_fill_q <= val_room ? value_fill_q + hkvp_pkg::FILL_W'(1) : FILL_OVER;
				end else if (!sts.val_end) begin
					value_fill_q <= '0;
				end
			end

			if (cmd.emit_key) begin
				ptr_q <= sts.key_done ? '0 : ptr_next[hkvp_pkg::PTR_W-1:0];
			end else if (cmd.emit_val) begin
				ptr_q <= sts.val_done ? '0 : ptr_next[hkvp_pkg::PTR_W-1:0];
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// match flags follow the key token as it is stored
	always_ff @(posedge clk) begin
		if (cmd.feed_key && printable && key_room) begin
			http_q <= (key_first || http_q) &&
				((key_fill_q >= hkvp_pkg::HTTP_LEN) || (data_byte == hkvp_pkg::http_char(pos)));
			ok_q   <= (key_first || ok_q) &&
				((key_fill_q >= hkvp_pkg::CODE_LEN) || (data_byte == hkvp_pkg::code_char(pos)));
			mark_q <= (key_first || mark_q) &&
				((key_fill_q >= hkvp_pkg::MARK_LEN) || (data_byte == hkvp_pkg::mark_char(pos)));
		end
	end

	// store writes, registered store read straight into the output payload
	always_ff @(posedge clk) begin
		if (cmd.feed_key && printable && key_room) begin
			key_store[key_fill_q[hkvp_pkg::PTR_W-1:0]] <= data_byte;
		end
		if (cmd.feed_val && printable && val_room) begin
			value_store[value_fill_q[hkvp_pkg::PTR_W-1:0]] <= data_byte;
		end
		if (cmd.emit_key) begin
			kind_q   <= hkvp_pkg::KIND_KEY;
			char_q   <= key_store[ptr_q];
			status_q <= hkvp_pkg::STAT_OK;
			last_q   <= 1'b0;
		end else if (cmd.emit_val) begin
			kind_q   <= hkvp_pkg::KIND_VALUE;
			char_q   <= value_store[ptr_q];
			status_q <= hkvp_pkg::STAT_OK;
			last_q   <= sts.val_done;
		end else if (cmd.load_status) begin
			kind_q   <= hkvp_pkg::KIND_STATUS;
			char_q   <= 8'd0;
			status_q <= cmd.status;
			last_q   <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = kind_q;
	assign out_char   = char_q;
	assign out_status = status_q;
	assign out_last   = last_q;

endmodule

// ===== rtl/hkvp_ctrl.sv =====
// parse phase and emission state machine of the key/value parser
`include "http_response_key_value_parser_unit_defines.svh"

module hkvp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  hkvp_pkg::action_t    action,
	input  hkvp_pkg::dp_sts_t    sts,
	output hkvp_pkg::dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_KEY,
		ST_VAL
	} state_t;

	typedef enum logic [2:0] {
		PH_BEGIN,
		PH_CODE,
		PH_HEAD,
		PH_KEY,
		PH_VALUE
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic   halted_q;
	logic   got_ok_q;
	logic   acc;

	assign s_tready = (state_q == ST_RUN) && sts.out_free;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		cmd = '0;
		if (acc) begin
			if (action == hkvp_pkg::ACT_NEW) begin
				cmd.clear = 1'b1;
			end else if (!halted_q) begin
				case (action)
					hkvp_pkg::ACT_EOS: begin
						cmd.load_status = 1'b1;
						cmd.status = got_ok_q ? hkvp_pkg::STAT_OK : hkvp_pkg::STAT_NO_200;
					end
					hkvp_pkg::ACT_ERR: begin
						cmd.load_status = 1'b1;
						cmd.status = hkvp_pkg::STAT_READ_ERR;
					end
					hkvp_pkg::ACT_DATA: begin
						if (phase_q == PH_VALUE) begin
							cmd.feed_val = 1'b1;
						end else begin
							cmd.feed_key = 1'b1;
							cmd.hold_key = phase_q == PH_KEY;
							if (phase_q == PH_CODE && sts.key_end && !sts.hit_200) begin
								cmd.load_status = 1'b1;
								cmd.status = hkvp_pkg::STAT_HTTP_ERR;
							end
						end
					end
					default: begin
						cmd.clear = 1'b0;
					end
				endcase
			end
		end
		cmd.emit_key = (state_q == ST_KEY) && sts.out_free;
		cmd.emit_val = (state_q == ST_VAL) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RUN;
			phase_q  <= PH_BEGIN;
			halted_q <= 1'b0;
			got_ok_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (cmd.clear) begin
						phase_q  <= PH_BEGIN;
						halted_q <= 1'b0;
						got_ok_q <= 1'b0;
					end else if (acc && !halted_q) begin
						if (action != hkvp_pkg::ACT_DATA) begin
							halted_q <= 1'b1;
						end else if (phase_q == PH_VALUE) begin
							if (sts.val_end) begin
								state_q <= ST_KEY;
							end
						end else if (sts.key_end) begin
							case (phase_q)
								PH_BEGIN: begin
									if (sts.hit_http) begin
										phase_q <= PH_CODE;
									end
								end
								PH_CODE: begin
									if (sts.hit_200) begin
										got_ok_q <= 1'b1;
										phase_q  <= PH_HEAD;
									end else begin
										halted_q <= 1'b1;
									end
								end
								PH_HEAD: begin
									if (sts.hit_mark) begin
										phase_q <= PH_KEY;
									end
								end
								PH_KEY: begin
									phase_q <= PH_VALUE;
								end
								default: begin
									phase_q <= PH_BEGIN;
								end
							endcase
						end
					end
				end
				ST_KEY: begin
					if (sts.out_free && sts.key_done) begin
						state_q <= ST_VAL;
					end
				end
				ST_VAL: begin
					if (sts.out_free && sts.val_done) begin
						state_q <= ST_RUN;
						phase_q <= PH_KEY;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	`HKVP_ASSERT_NOW(a_emit_in_value, clk, arst_n, state_q != ST_RUN, phase_q == PH_VALUE)
	`HKVP_ASSERT_NEXT(a_halt_sticky, clk, arst_n, halted_q && !cmd.clear, halted_q)
	`HKVP_ASSERT_NEXT(a_key_to_val, clk, arst_n, cmd.emit_key && sts.key_done, state_q == ST_VAL)

endmodule

// ===== rtl/http_response_key_value_parser_unit.sv =====
// top level of the http response key/value parser
// a status result is registered and appears in the cycle after the transfer that causes it
// throughput: one input byte per cycle while no pair is being emitted and the output register is free
// a completed value token stalls input while its key and value are emitted, one stored
// character per cycle while the output register is free, read from the token stores into the output register
// reset: arst_n clears phase, halt and fill state at once; stores need no clearing pass
module http_response_key_value_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] action
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_char, [9:8] status, [15:10] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last value character or status result
);

	hkvp_pkg::dp_cmd_t cmd;
	hkvp_pkg::dp_sts_t sts;
	hkvp_pkg::kind_t   out_kind;
	hkvp_pkg::status_t out_status;
	logic [7:0]        out_char;

	// controller: parse phase, halt flag and pair emission sequencing
	hkvp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (hkvp_pkg::action_t'(s_tuser)),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: tokenizers, token stores and the output register
	hkvp_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (s_tdata),
		.m_tready   (m_tready),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_kind   (out_kind),
		.out_char   (out_char),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	// pack result fields, lowest field first, padded to two bytes
	assign m_tdata = {6'd0, out_status, out_char};
	assign m_tuser = out_kind;

endmodule
